### hw/rtl/php_pkg.sv
// ----------------------------------------------------------------------------
// php_pkg
// Shared types and constants for the packet header parser.
// ----------------------------------------------------------------------------
package php_pkg;

    localparam int TCP_PAYLOAD_MAX   = 80;
    localparam int SHORT_PAYLOAD_MAX = 32;
    localparam int HDR_DEPTH         = 28;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ETH     = 4'd1,
        PH_IPV4    = 4'd2,
        PH_IPOPT   = 4'd3,
        PH_ICMP    = 4'd4,
        PH_UDP     = 4'd5,
        PH_TCP     = 4'd6,
        PH_TCPOPT  = 4'd7,
        PH_ARP     = 4'd8,
        PH_PAYLOAD = 4'd9,
        PH_SKIP    = 4'd10
    } phase_t;

    localparam logic [3:0] REC_ETHER   = 4'd0;
    localparam logic [3:0] REC_IPV4    = 4'd1;
    localparam logic [3:0] REC_ICMP    = 4'd2;
    localparam logic [3:0] REC_UDP     = 4'd3;
    localparam logic [3:0] REC_TCP     = 4'd4;
    localparam logic [3:0] REC_ARP     = 4'd5;
    localparam logic [3:0] REC_ARP_UNK = 4'd6;
    localparam logic [3:0] REC_PAYLOAD = 4'd7;
    localparam logic [3:0] REC_NO_DATA = 4'd8;
    localparam logic [3:0] REC_LEN_ERR = 4'd9;
    localparam logic [3:0] REC_TRUNC   = 4'd10;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // result record; all fields but last_of_run go into the 248 bits of tdata, last_of_run into tlast
    typedef struct packed {
        logic        last_of_run;
        logic [7:0]  payload_byte;
        logic [7:0]  code_byte;
        logic [15:0] half_four;
        logic [15:0] half_three;
        logic [15:0] half_two;
        logic [15:0] half_one;
        logic [31:0] word_two;
        logic [31:0] word_one;
        logic [47:0] mac_two;
        logic [47:0] mac_one;
        logic [3:0]  rec_kind;
    } rec_t;

    // input item as held in the input register
    typedef struct packed {
        logic [15:0] original_length;
        logic [15:0] captured_length;
        logic        last_byte;
        logic        first_byte;
        logic [7:0]  data_byte;
    } item_t;

endpackage

### hw/rtl/php_core.sv
// ----------------------------------------------------------------------------
// php_core
// Parse state, header byte store and per-byte record generation.
// ----------------------------------------------------------------------------
module php_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  php_pkg::item_t item,
    output logic [1:0]     rec_count,
    output php_pkg::rec_t  recs [3]
);
    import php_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] offset_reg, offset_next;
    logic [5:0]  ihl_reg, ihl_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] caplen_reg, caplen_next;
    logic [6:0]  remain_reg, remain_next;
    logic [7:0]  hdr_reg [HDR_DEPTH];

    logic        wr_en;
    logic [4:0]  wr_pos;

    // header view with the current byte merged in
    logic [7:0]  h [HDR_DEPTH];

    logic [15:0] off, pos, ts;
    logic        last;
    phase_t      ph;
    rec_t        r [3];
    logic [1:0]  n;

    logic signed [18:0] room, plen;
    logic [6:0]  cap_lim;
    logic        do_pay;
    logic        pay_ok;
    logic [5:0]  thl;
    logic [15:0] ulen;

    function automatic logic [15:0] g16(input logic [7:0] a, input logic [7:0] b);
        g16 = {a, b};
    endfunction

    always_comb
    begin
        for (int i = 0; i < HDR_DEPTH; i++)
        begin
            h[i] = hdr_reg[i];
        end
        if (wr_en)
        begin
            h[wr_pos] = item.data_byte;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        ihl_next    = ihl_reg;
        total_next  = total_reg;
        caplen_next = caplen_reg;
        remain_next = remain_reg;
        wr_en       = 1'b0;
        wr_pos      = '0;
        n           = '0;
        r[0]        = '0;
        r[1]        = '0;
        r[2]        = '0;
        do_pay      = 1'b0;
        plen        = '0;
        cap_lim     = 7'(SHORT_PAYLOAD_MAX);
        pay_ok      = 1'b0;
        room        = '0;
        thl         = '0;
        ulen        = '0;
        last        = item.last_byte;
        ph          = phase_reg;
        off         = offset_reg;
        pos         = '0;
        ts          = 16'd14 + ((ihl_reg < 6'd20) ? 16'd20 : {10'd0, ihl_reg});

        if (item.first_byte)
        begin
            off         = '0;
            ph          = PH_ETH;
            caplen_next = item.captured_length;
            ihl_next    = '0;
            total_next  = '0;
            remain_next = '0;
            ts          = 16'd34;
            if (item.captured_length > item.original_length)
            begin
                r[0].rec_kind = REC_LEN_ERR;
                r[0].half_one = item.captured_length;
                r[0].half_two = item.original_length;
                n = 2'd1;
            end
        end
        else if (phase_reg == PH_IDLE || phase_reg > PH_SKIP)
        begin
            ph = PH_IDLE;
        end

        if (ph != PH_IDLE)
        begin
            case (ph)
                PH_ETH:
                begin
                    if (off < 16'(HDR_DEPTH))
                    begin
                        wr_en  = 1'b1;
                        wr_pos = off[4:0];
                    end
                    if (off == 16'd13)
                    begin
                        r[n].rec_kind = REC_ETHER;
                        r[n].mac_one  = {h[0], h[1], h[2], h[3], h[4], h[5]};
                        r[n].mac_two  = {h[6], h[7], h[8], h[9], h[10], h[11]};
                        r[n].half_one = g16(h[12], h[13]);
                        n = n + 2'd1;
                        ph = (g16(h[12], h[13]) == ETYPE_IPV4) ? PH_IPV4 :
                             (g16(h[12], h[13]) == ETYPE_ARP) ? PH_ARP : PH_SKIP;
                    end
                end
                PH_IPV4, PH_IPOPT:
                begin
                    if (ph == PH_IPV4)
                    begin
                        pos = off - 16'd14;
                        if (pos < 16'(HDR_DEPTH))
                        begin
                            wr_en  = 1'b1;
                            wr_pos = pos[4:0];
                        end
                    end
                    if ((ph == PH_IPV4 && pos == 16'd19 && {h[0][3:0], 2'b00} <= 6'd20) ||
                        (ph == PH_IPOPT && (off + 16'd1) >= (16'd14 + {10'd0, ihl_reg})))
                    begin
                        if (ph == PH_IPV4)
                        begin
                            ihl_next   = {h[0][3:0], 2'b00};
                            total_next = g16(h[2], h[3]);
                        end
                        r[n].rec_kind  = REC_IPV4;
                        r[n].word_one  = {h[12], h[13], h[14], h[15]};
                        r[n].word_two  = {h[16], h[17], h[18], h[19]};
                        r[n].code_byte = h[9];
                        n = n + 2'd1;
                        ph = (h[9] == PROTO_ICMP) ? PH_ICMP :
                             (h[9] == PROTO_UDP) ? PH_UDP :
                             (h[9] == PROTO_TCP) ? PH_TCP : PH_SKIP;
                    end
                    else if (ph == PH_IPV4 && pos == 16'd19)
                    begin
                        ihl_next   = {h[0][3:0], 2'b00};
                        total_next = g16(h[2], h[3]);
                        ph = PH_IPOPT;
                    end
                end
                PH_ICMP, PH_UDP:
                begin
                    pos = off - ts;
                    if (pos < 16'(HDR_DEPTH))
                    begin
                        wr_en  = 1'b1;
                        wr_pos = pos[4:0];
                    end
                    if (pos == 16'd7)
                    begin
                        do_pay = 1'b1;
                        if (ph == PH_ICMP)
                        begin
                            r[n].rec_kind  = REC_ICMP;
                            r[n].half_one  = g16(h[4], h[5]);
                            r[n].half_two  = g16(h[6], h[7]);
                            r[n].code_byte = (h[0] == 8'd8 && h[1] == 8'd0) ? 8'd0 :
                                             (h[0] == 8'd0 && h[1] == 8'd0) ? 8'd1 : 8'd2;
                            plen = 19'(signed'({1'b0, total_reg})) -
                                   19'(signed'({1'b0, ihl_reg})) - 19'sd8;
                        end
                        else
                        begin
                            ulen = g16(h[4], h[5]);
                            r[n].rec_kind   = REC_UDP;
                            r[n].half_one   = g16(h[0], h[1]);
                            r[n].half_two   = g16(h[2], h[3]);
                            r[n].half_three = ulen;
                            plen = 19'(signed'({1'b0, ulen})) - 19'sd8;
                        end
                        n = n + 2'd1;
                    end
                end
                PH_TCP, PH_TCPOPT:
                begin
                    pos = off - ts;
                    thl = {h[12][7:4], 2'b00};
                    if (ph == PH_TCP)
                    begin
                        if (pos < 16'(HDR_DEPTH))
                        begin
                            wr_en  = 1'b1;
                            wr_pos = pos[4:0];
                        end
                        if (pos == 16'd19)
                        begin
                            r[n].rec_kind   = REC_TCP;
                            r[n].half_one   = g16(h[0], h[1]);
                            r[n].half_two   = g16(h[2], h[3]);
                            r[n].word_one   = {h[4], h[5], h[6], h[7]};
                            r[n].word_two   = {h[8], h[9], h[10], h[11]};
                            r[n].half_three = g16(h[14], h[15]);
                            r[n].half_four  = g16(h[18], h[19]);
                            r[n].code_byte  = h[13];
                            n = n + 2'd1;
                            if (thl > 6'd20)
                                ph = PH_TCPOPT;
                            else
                                do_pay = 1'b1;
                        end
                    end
                    else if ((off + 16'd1) >= (ts + {10'd0, thl}))
                    begin
                        do_pay = 1'b1;
                    end
                    cap_lim = 7'(TCP_PAYLOAD_MAX);
                    plen = 19'(signed'({1'b0, total_reg})) -
                           19'(signed'({1'b0, ihl_reg})) - 19'(signed'({1'b0, thl}));
                end
                PH_ARP:
                begin
                    pos = off - 16'd14;
                    if (pos < 16'(HDR_DEPTH))
                    begin
                        wr_en  = 1'b1;
                        wr_pos = pos[4:0];
                    end
                    if (pos == 16'd27)
                    begin
                        if (g16(h[0], h[1]) == 16'd1 && g16(h[2], h[3]) == ETYPE_IPV4)
                        begin
                            r[n].rec_kind   = REC_ARP;
                            r[n].mac_one    = {h[8], h[9], h[10], h[11], h[12], h[13]};
                            r[n].mac_two    = {h[18], h[19], h[20], h[21], h[22], h[23]};
                            r[n].word_one   = {h[14], h[15], h[16], h[17]};
                            r[n].word_two   = {h[24], h[25], h[26], h[27]};
                            r[n].half_three = g16(h[6], h[7]);
                            r[n].half_four  = g16(h[4], h[5]);
                        end
                        else
                        begin
                            r[n].rec_kind = REC_ARP_UNK;
                        end
                        r[n].half_one = g16(h[0], h[1]);
                        r[n].half_two = g16(h[2], h[3]);
                        n = n + 2'd1;
                        ph = PH_SKIP;
                    end
                end
                PH_PAYLOAD:
                begin
                    r[n].rec_kind     = REC_PAYLOAD;
                    r[n].payload_byte = item.data_byte;
                    n = n + 2'd1;
                    if (remain_reg > 7'd0)
                        remain_next = remain_reg - 7'd1;
                    if (remain_next == 7'd0)
                        ph = PH_SKIP;
                end
                default:
                begin
                end
            endcase

            // clamp the payload length to captured room, then to its maximum
            if (do_pay)
            begin
                room = 19'(signed'({1'b0, caplen_next})) - 19'(signed'({1'b0, off})) - 19'sd1;
                if (plen > room)
                    plen = room;
                if (plen > 19'(signed'({1'b0, cap_lim})))
                    plen = 19'(signed'({1'b0, cap_lim}));
                pay_ok = (plen > 19'sd0);
                if (pay_ok)
                begin
                    remain_next = plen[6:0];
                    ph = PH_PAYLOAD;
                end
                else
                begin
                    ph = PH_SKIP;
                    if (cap_lim == 7'(TCP_PAYLOAD_MAX))
                    begin
                        r[n].rec_kind = REC_NO_DATA;
                        n = n + 2'd1;
                    end
                end
            end

            if (last)
            begin
                if (ph != PH_SKIP)
                begin
                    r[n].rec_kind = REC_TRUNC;
                    n = n + 2'd1;
                end
                ph = PH_IDLE;
                offset_next = '0;
            end
            else if (off != 16'hFFFF)
            begin
                offset_next = off + 16'd1;
            end
            else
            begin
                offset_next = off;
            end
        end
        phase_next = ph;
        if (n != 2'd0)
            r[n - 2'd1].last_of_run = 1'b1;
    end

    assign rec_count = n;
    assign recs      = r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            offset_reg <= '0;
            ihl_reg    <= '0;
            total_reg  <= '0;
            caplen_reg <= '0;
            remain_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            ihl_reg    <= ihl_next;
            total_reg  <= total_next;
            caplen_reg <= caplen_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && wr_en)
            hdr_reg[wr_pos] <= item.data_byte;
    end

endmodule

### hw/rtl/php_out_queue.sv
// ----------------------------------------------------------------------------
// php_out_queue
// Holds up to three records of one byte and drains them one per cycle while tready is high.
// ----------------------------------------------------------------------------
module php_out_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic [1:0]     load_count,
    input  php_pkg::rec_t  load_recs [3],
    output logic           empty_next,
    output logic           tvalid,
    input  logic           tready,
    output php_pkg::rec_t  tdata
);
    import php_pkg::*;

    rec_t       slot_reg [3];
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop        = tvalid && tready;
    assign tvalid     = (count_reg != 2'd0);
    assign tdata      = slot_reg[0];
    // free for a new load when at most the head is left and it leaves now
    assign empty_next = (count_reg == 2'd0) || (count_reg == 2'd1 && pop);

    always_comb
    begin
        count_next = count_reg;
        if (pop)
            count_next = count_reg - 2'd1;
        if (load)
            count_next = load_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg[0] <= load_recs[0];
            slot_reg[1] <= load_recs[1];
            slot_reg[2] <= load_recs[2];
        end
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

### hw/rtl/packet_header_parser_unit.sv
// ----------------------------------------------------------------------------
// packet_header_parser_unit
// Ethernet / IPv4 / ARP / ICMP / UDP / TCP header parser, one frame byte per
// transaction, one record per master transaction.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                  tuser
//  s_axis    in   data_byte, captured_length, orig_len   first_byte
//  m_axis    out  record fields (rec_kind .. payload)    -
//
//  One byte per cycle: input register, parse logic, a three-deep record queue.
//  A byte giving one record or none flows at full rate while the master is
//  ready; a byte giving two or three records holds the input while the queue
//  drains. Each byte is registered at the input and its records in the queue.
//  Reset clears the parse phase and all counters; the header store is not
//  cleared. A stalled master side holds the input once the register is full.
// ----------------------------------------------------------------------------
module packet_header_parser_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] data_byte, [23:8] captured_length, [39:24] original_length
    input  logic [39:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    // [0] first_byte
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] rec_kind, [51:4] mac_one, [99:52] mac_two, [131:100] word_one,
    // [163:132] word_two, [179:164] half_one, [195:180] half_two,
    // [211:196] half_three, [227:212] half_four, [235:228] code_byte,
    // [243:236] payload_byte, rest zero
    output logic [247:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import php_pkg::*;

    item_t      in_reg;
    logic       in_valid_reg;
    logic       step;
    logic       empty_next;
    logic [1:0] rec_count;
    rec_t       recs [3];
    rec_t       head;

    // advance the held byte once the queue can take its records
    assign step          = in_valid_reg && empty_next;
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg.data_byte       <= s_axis_tdata[7:0];
            in_reg.captured_length <= s_axis_tdata[23:8];
            in_reg.original_length <= s_axis_tdata[39:24];
            in_reg.first_byte      <= s_axis_tuser;
            in_reg.last_byte       <= s_axis_tlast;
        end
    end

    php_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_reg),
        .rec_count (rec_count),
        .recs      (recs)
    );

    php_out_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .load_count (rec_count),
        .load_recs  (recs),
        .empty_next (empty_next),
        .tvalid     (m_axis_tvalid),
        .tready     (m_axis_tready),
        .tdata      (head)
    );

    assign m_axis_tdata = {4'd0, head.payload_byte, head.code_byte, head.half_four,
                           head.half_three, head.half_two, head.half_one,
                           head.word_two, head.word_one, head.mac_two, head.mac_one,
                           head.rec_kind};
    assign m_axis_tlast = head.last_of_run;

endmodule

### hw/rtl/php_checker.sv
// ----------------------------------------------------------------------------
// php_checker
// Port-level checks for the packet header parser.
// ----------------------------------------------------------------------------
module php_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [247:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    import php_pkg::*;

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= REC_TRUNC)
        else $error("record kind out of range");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[247:244] == 4'd0)
        else $error("tdata padding not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled record changed");

    a_ready_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !s_axis_tvalid |=> s_axis_tready)
        else $error("input stalled with nothing pending");

endmodule

bind packet_header_parser_unit php_checker u_php_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/packet_header_parser_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_header_parser_checker
// Watches both channels of the header parser, predicts the records each
// accepted byte should produce and compares them in order with the output.
// ----------------------------------------------------------------------------
module packet_header_parser_checker
    import php_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [247:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           records_pending
);

    rec_t        record_fifo[$];
    rec_t        byte_recs[$];
    logic [15:0] offset;
    phase_t      phase;
    logic [7:0]  hdr[HDR_DEPTH];
    int          ihl_bytes;
    int          ip_total;
    int          cap_len;
    int          remain;

    function automatic logic [63:0] grab(int pos, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
        begin
            v = v << 8;
            if (pos + i < HDR_DEPTH)
                v[7:0] = hdr[pos + i];
        end
        return v;
    endfunction

    function automatic rec_t blank(logic [3:0] kind);
        rec_t r;
        r = '0;
        r.rec_kind = kind;
        return r;
    endfunction

    function automatic void keep(int pos, logic [7:0] b);
        if (pos >= 0 && pos < HDR_DEPTH)
            hdr[pos] = b;
    endfunction

    // clamp payload length; enter payload or skip
    function automatic bit begin_payload(int len, int limit, int off);
        int room;
        room = cap_len - (off + 1);
        if (len > room)
            len = room;
        if (len > limit)
            len = limit;
        if (len > 0)
        begin
            remain = len & 8'h7F;
            phase  = PH_PAYLOAD;
            return 1'b1;
        end
        phase = PH_SKIP;
        return 1'b0;
    endfunction

    function automatic void ip_header_done();
        rec_t r;
        r           = blank(REC_IPV4);
        r.word_one  = grab(12, 4);
        r.word_two  = grab(16, 4);
        r.code_byte = hdr[9];
        byte_recs.push_back(r);
        if (hdr[9] == PROTO_ICMP)
            phase = PH_ICMP;
        else if (hdr[9] == PROTO_UDP)
            phase = PH_UDP;
        else if (hdr[9] == PROTO_TCP)
            phase = PH_TCP;
        else
            phase = PH_SKIP;
    endfunction

    function automatic void tcp_payload_start(int off);
        int len;
        len = ip_total - ihl_bytes - int'(hdr[12][7:4]) * 4;
        if (!begin_payload(len, TCP_PAYLOAD_MAX, off))
            byte_recs.push_back(blank(REC_NO_DATA));
    endfunction

    // advance the parser by one accepted byte, queue its records
    function automatic void parse_byte(logic [7:0] b, logic first, logic last,
                                       logic [15:0] cap, logic [15:0] orig);
        int   off;
        int   pos;
        int   ts;
        rec_t r;
        byte_recs.delete();
        if (first)
        begin
            offset    = '0;
            phase     = PH_ETH;
            cap_len   = cap;
            ihl_bytes = 0;
            ip_total  = 0;
            remain    = 0;
            if (cap > orig)
            begin
                r          = blank(REC_LEN_ERR);
                r.half_one = cap;
                r.half_two = orig;
                byte_recs.push_back(r);
            end
        end
        else if (phase == PH_IDLE)
            return;

        off = offset;
        ts  = 14 + (ihl_bytes < 20 ? 20 : ihl_bytes);
        case (phase)
            PH_ETH:
            begin
                keep(off, b);
                if (off == 13)
                begin
                    r          = blank(REC_ETHER);
                    r.mac_one  = grab(0, 6);
                    r.mac_two  = grab(6, 6);
                    r.half_one = grab(12, 2);
                    byte_recs.push_back(r);
                    phase = (r.half_one == ETYPE_IPV4) ? PH_IPV4 :
                            (r.half_one == ETYPE_ARP) ? PH_ARP : PH_SKIP;
                end
            end
            PH_IPV4:
            begin
                pos = off - 14;
                keep(pos, b);
                if (pos == 19)
                begin
                    ihl_bytes = int'(hdr[0][3:0]) * 4;
                    ip_total  = grab(2, 2);
                    if (ihl_bytes > 20)
                        phase = PH_IPOPT;
                    else
                        ip_header_done();
                end
            end
            PH_IPOPT:
                if (off + 1 >= 14 + ihl_bytes)
                    ip_header_done();
            PH_ICMP, PH_UDP:
            begin
                pos = off - ts;
                keep(pos, b);
                if (pos == 7)
                begin
                    if (phase == PH_ICMP)
                    begin
                        r          = blank(REC_ICMP);
                        r.half_one = grab(4, 2);
                        r.half_two = grab(6, 2);
                        if (hdr[0] == 8'd8 && hdr[1] == 8'd0)
                            r.code_byte = 8'd0;
                        else if (hdr[0] == 8'd0 && hdr[1] == 8'd0)
                            r.code_byte = 8'd1;
                        else
                            r.code_byte = 8'd2;
                        byte_recs.push_back(r);
                        void'(begin_payload(ip_total - ihl_bytes - 8,
                                            SHORT_PAYLOAD_MAX, off));
                    end
                    else
                    begin
                        r            = blank(REC_UDP);
                        r.half_one   = grab(0, 2);
                        r.half_two   = grab(2, 2);
                        r.half_three = grab(4, 2);
                        byte_recs.push_back(r);
                        void'(begin_payload(int'(r.half_three) - 8,
                                            SHORT_PAYLOAD_MAX, off));
                    end
                end
            end
            PH_TCP:
            begin
                pos = off - ts;
                keep(pos, b);
                if (pos == 19)
                begin
                    r            = blank(REC_TCP);
                    r.half_one   = grab(0, 2);
                    r.half_two   = grab(2, 2);
                    r.word_one   = grab(4, 4);
                    r.word_two   = grab(8, 4);
                    r.half_three = grab(14, 2);
                    r.half_four  = grab(18, 2);
                    r.code_byte  = hdr[13];
                    byte_recs.push_back(r);
                    if (int'(hdr[12][7:4]) * 4 > 20)
                        phase = PH_TCPOPT;
                    else
                        tcp_payload_start(off);
                end
            end
            PH_TCPOPT:
                if (off + 1 >= ts + int'(hdr[12][7:4]) * 4)
                    tcp_payload_start(off);
            PH_ARP:
            begin
                pos = off - 14;
                keep(pos, b);
                if (pos == 27)
                begin
                    if (grab(0, 2) == 1 && grab(2, 2) == ETYPE_IPV4)
                    begin
                        r            = blank(REC_ARP);
                        r.mac_one    = grab(8, 6);
                        r.mac_two    = grab(18, 6);
                        r.word_one   = grab(14, 4);
                        r.word_two   = grab(24, 4);
                        r.half_three = grab(6, 2);
                        r.half_four  = grab(4, 2);
                    end
                    else
                        r = blank(REC_ARP_UNK);
                    r.half_one = grab(0, 2);
                    r.half_two = grab(2, 2);
                    byte_recs.push_back(r);
                    phase = PH_SKIP;
                end
            end
            PH_PAYLOAD:
            begin
                r              = blank(REC_PAYLOAD);
                r.payload_byte = b;
                byte_recs.push_back(r);
                if (remain > 0)
                    remain--;
                if (remain == 0)
                    phase = PH_SKIP;
            end
            default: ;
        endcase

        if (last)
        begin
            if (phase != PH_SKIP)
                byte_recs.push_back(blank(REC_TRUNC));
            phase  = PH_IDLE;
            offset = '0;
        end
        else if (offset != 16'hFFFF)
            offset++;

        if (byte_recs.size() > 0)
            byte_recs[byte_recs.size() - 1].last_of_run = 1'b1;
        foreach (byte_recs[i])
            record_fifo.push_back(byte_recs[i]);
    endfunction

    function automatic void report(string field, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    endfunction

    function automatic int compare(rec_t want, rec_t got);
        int bad;
        bad = 0;
        if (want.rec_kind != got.rec_kind)
        begin
            report("rec_kind", want.rec_kind, got.rec_kind); bad++;
        end
        if (want.mac_one != got.mac_one)
        begin
            report("mac_one", want.mac_one, got.mac_one); bad++;
        end
        if (want.mac_two != got.mac_two)
        begin
            report("mac_two", want.mac_two, got.mac_two); bad++;
        end
        if (want.word_one != got.word_one)
        begin
            report("word_one", want.word_one, got.word_one); bad++;
        end
        if (want.word_two != got.word_two)
        begin
            report("word_two", want.word_two, got.word_two); bad++;
        end
        if (want.half_one != got.half_one)
        begin
            report("half_one", want.half_one, got.half_one); bad++;
        end
        if (want.half_two != got.half_two)
        begin
            report("half_two", want.half_two, got.half_two); bad++;
        end
        if (want.half_three != got.half_three)
        begin
            report("half_three", want.half_three, got.half_three); bad++;
        end
        if (want.half_four != got.half_four)
        begin
            report("half_four", want.half_four, got.half_four); bad++;
        end
        if (want.code_byte != got.code_byte)
        begin
            report("code_byte", want.code_byte, got.code_byte); bad++;
        end
        if (want.payload_byte != got.payload_byte)
        begin
            report("payload_byte", want.payload_byte, got.payload_byte); bad++;
        end
        if (want.last_of_run != got.last_of_run)
        begin
            report("last_of_run", want.last_of_run, got.last_of_run); bad++;
        end
        return bad;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rec_t got;
        if (!rst_n)
        begin
            record_fifo.delete();
            offset          = '0;
            phase           = PH_IDLE;
            ihl_bytes       = 0;
            ip_total        = 0;
            cap_len         = 0;
            remain          = 0;
            fail_count      <= 0;
            records_pending <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tlast,
                           s_axis_tdata[23:8], s_axis_tdata[39:24]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = rec_t'({m_axis_tlast, m_axis_tdata[243:0]});
                if (record_fifo.size() == 0)
                begin
                    $display("%0t: unexpected record kind %0d", $time, got.rec_kind);
                    fail_count <= fail_count + 1;
                end
                else if (compare(record_fifo.pop_front(), got) != 0)
                    fail_count <= fail_count + 1;
            end
            records_pending <= record_fifo.size();
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the header parser with generated frames (ICMP, UDP, TCP, ARP, other
// types, options, truncation, length errors, stray bytes, abandoned frames),
// idles both channels in random bursts and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import php_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [247:0] m_axis_tdata;
    logic         m_axis_tlast;
    int           fail_count;
    int           records_pending;

    // when set, neither side idles
    bit           quiet = 1'b0;
    // one-shot request for a long receiver stall
    bit           hold_request = 1'b0;
    int           bytes_sent = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    packet_header_parser_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    packet_header_parser_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .fail_count      (fail_count),
        .records_pending (records_pending)
    );

    // Offer one byte and hold it until the transaction completes. Handshake
    // is sampled at the falling edge, where every signal has settled.
    task automatic send_byte(logic [7:0] b, logic first, logic last,
                             logic [15:0] cap, logic [15:0] orig);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {orig, cap, b};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    // Build one frame. Kind: 0 ICMP, 1 UDP, 2 TCP, 3 ARP, 4 ARP of unknown
    // type, 5 other ethertype, 6 other IP protocol.
    task automatic build_frame(int kind, output logic [7:0] f[$]);
        int          ihl;
        int          doff;
        int          pl;
        int          l4;
        logic [15:0] total;
        logic [15:0] etype;
        logic [7:0]  proto;
        f.delete();
        repeat (12) f.push_back(rnd8());
        case (kind)
            3, 4:    etype = ETYPE_ARP;
            5:       etype = 16'($urandom);
            default: etype = ETYPE_IPV4;
        endcase
        f.push_back(etype[15:8]);
        f.push_back(etype[7:0]);
        if (kind == 3 || kind == 4)
        begin
            if (kind == 3)
            begin
                f.push_back(8'h00); f.push_back(8'h01);
                f.push_back(8'h08); f.push_back(8'h00);
            end
            else
                repeat (4) f.push_back(rnd8());
            repeat (24) f.push_back(rnd8());
            return;
        end
        if (kind == 5)
        begin
            repeat ($urandom_range(0, 12)) f.push_back(rnd8());
            return;
        end
        // IPv4: mostly a plain header, sometimes options or a short IHL
        case ($urandom_range(0, 9))
            7, 8:    ihl = $urandom_range(6, 15);
            9:       ihl = $urandom_range(0, 4);
            default: ihl = 5;
        endcase
        case ($urandom_range(0, 9))
            7, 8:    doff = $urandom_range(6, 15);
            9:       doff = $urandom_range(0, 4);
            default: doff = 5;
        endcase
        pl    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 90) : $urandom_range(0, 12);
        proto = (kind == 0) ? PROTO_ICMP : (kind == 1) ? PROTO_UDP :
                (kind == 2) ? PROTO_TCP : rnd8();
        l4    = (kind == 2) ? doff * 4 : 8;
        total = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(ihl * 4 + l4 + pl);
        f.push_back(($urandom_range(0, 5) == 0) ? {4'($urandom), 4'(ihl)} : {4'h4, 4'(ihl)});
        f.push_back(rnd8());
        f.push_back(total[15:8]);
        f.push_back(total[7:0]);
        repeat (5) f.push_back(rnd8());
        f.push_back(proto);
        repeat (10) f.push_back(rnd8());
        if (ihl > 5)
            repeat (ihl * 4 - 20) f.push_back(rnd8());
        case (kind)
            0:
            begin
                case ($urandom_range(0, 2))
                    0:       f.push_back(8'd8);
                    1:       f.push_back(8'd0);
                    default: f.push_back(rnd8());
                endcase
                f.push_back(($urandom_range(0, 3) == 0) ? rnd8() : 8'd0);
                repeat (6) f.push_back(rnd8());
            end
            1:
            begin
                repeat (4) f.push_back(rnd8());
                total = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(8 + pl);
                f.push_back(total[15:8]);
                f.push_back(total[7:0]);
                repeat (2) f.push_back(rnd8());
            end
            2:
            begin
                repeat (12) f.push_back(rnd8());
                f.push_back({4'(doff), 4'($urandom)});
                repeat (7) f.push_back(rnd8());
                if (doff > 5)
                    repeat (doff * 4 - 20) f.push_back(rnd8());
            end
            default: ;
        endcase
        repeat (pl) f.push_back(rnd8());
    endtask

    // Send a frame. Occasionally cut it, misstate its lengths, precede it
    // with stray bytes, or leave out the last marker so the next frame
    // abandons it.
    task automatic send_frame(logic [7:0] f[$], bit mangle);
        int          n;
        logic [15:0] cap;
        logic [15:0] orig;
        bit          drop_last;
        n         = f.size();
        drop_last = 1'b0;
        if (mangle)
        begin
            if ($urandom_range(0, 5) == 0)
                n = $urandom_range(1, f.size());
            drop_last = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(rnd8(), 1'b0, 1'($urandom), 16'($urandom), 16'($urandom));
        end
        cap  = (mangle && $urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(n);
        orig = (mangle && $urandom_range(0, 7) == 0) ? 16'($urandom) :
               (mangle && $urandom_range(0, 7) == 0) ? cap - 16'd1 : cap;
        for (int i = 0; i < n; i++)
            send_byte(f[i], i == 0, (i == n - 1) && !drop_last,
                      (i == 0) ? cap : 16'($urandom), (i == 0) ? orig : 16'($urandom));
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (records_pending != 0);
        @(posedge clk);
    endtask

    // Receiver: random bursts of ready and not ready, one long stall on
    // request, always ready once the run goes quiet.
    initial
    begin
        forever
        begin
            if (quiet)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 9) < 7);
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [7:0] f[$];
        int         frames;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray byte while idle, one-byte frame, length error,
        // then one clean frame of each kind
        send_byte(8'hFF, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF);
        send_byte(8'h00, 1'b1, 1'b1, 16'hFFFF, 16'h0000);
        for (int k = 0; k < 7; k++)
        begin
            build_frame(k, f);
            send_frame(f, 1'b0);
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // random frames; stall the receiver once and drain fully once
        frames = 0;
        while (frames < 2 || bytes_sent < 300)
        begin
            if (frames == 0)
                hold_request = 1'b1;
            if (frames == 1)
            begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            build_frame(($urandom_range(0, 3) == 0) ? $urandom_range(3, 6)
                                                    : $urandom_range(0, 2), f);
            send_frame(f, 1'b1);
            frames++;
        end

        // last part: no idling
        quiet = 1'b1;
        build_frame($urandom_range(0, 6), f);
        send_frame(f, 1'b1);
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
